// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// File: rtl/rfr_pkg.sv
// Types and constants of the frame receiver.
package rfr_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int CNT_W     = $clog2(BUF_DEPTH) + 1;
  localparam int CMP_W     = 10;
  localparam int HDR_LEN   = 6;

  localparam logic [7:0] HDR0     = 8'h00;
  localparam logic [7:0] HDR1     = 8'hD7;
  localparam logic [7:0] HDR2     = 8'h29;
  localparam logic [7:0] POLY     = 8'h3C;
  localparam logic [7:0] STUFF    = 8'h00;
  localparam logic [3:0] ADDR_DEF = 4'h1;

  localparam logic [2:0] POS_HDR0 = 3'd0;
  localparam logic [2:0] POS_HDR1 = 3'd1;
  localparam logic [2:0] POS_HDR2 = 3'd2;
  localparam logic [2:0] POS_ADDR = 3'd3;
  localparam logic [2:0] POS_LEN  = 3'd5;

  typedef enum logic [3:0] {
    ST_HDR_OK      = 4'd0,
    ST_STORED      = 4'd1,
    ST_STUFF_DROP  = 4'd2,
    ST_FRAME_GOOD  = 4'd3,
    ST_CHECK_BAD   = 4'd4,
    ST_HDR_REJECT  = 4'd5,
    ST_ADDR_REJECT = 4'd6,
    ST_OVERFLOW    = 4'd7,
    ST_RESTARTED   = 4'd8
  } status_t;

endpackage

// File: rtl/rfr_in_if.sv
// Input channel of the frame receiver: received bytes and restart requests.
interface rfr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

// File: rtl/rfr_out_if.sv
// Output channel of the frame receiver: one status record per received item.
interface rfr_out_if;
  logic            valid;
  logic            ready;
  rfr_pkg::status_t status;
  logic [7:0]      stored_byte;
  logic [7:0]      byte_index;
  logic [7:0]      length_field;
  logic            frame_end;

  modport source (output valid, output status, output stored_byte, output byte_index,
                  output length_field, output frame_end, input ready);
  modport sink (input valid, input status, input stored_byte, input byte_index,
                input length_field, input frame_end, output ready);
endinterface

// File: rtl/rs485_frame_receiver.sv
// Frame receiver: checks header and address, removes stuffing, checks the checksum.
// The result of an item is registered and presented in the cycle after the item is taken.
// Throughput: one item per cycle; the single output register is the only stage,
// and a new item is taken whenever that register is empty or being emptied.
// Reset (synchronous, active high) empties the output register, clears the frame
// state and sets the device address to one.
`include "assert_macros.svh"

module rs485_frame_receiver (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic [3:0] cfg_data,
  rfr_in_if.sink    in_ch,
  rfr_out_if.source out_ch
);
  import rfr_pkg::*;

  logic [3:0]       device_address;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       frame_length;
  logic             stuff_pending;
  logic [7:0]       check_accum;
  logic [7:0]       held_byte;

  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]       frame_length_next;
  logic             stuff_pending_next;
  logic [7:0]       check_accum_next;
  logic [7:0]       held_byte_next;

  status_t    res_status;
  logic [7:0] res_byte;
  logic [7:0] res_index;
  logic       in_fire;
  logic [7:0] store_accum;
  logic [2:0] pos;

  function automatic logic [7:0] fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    c = {c[0], c[7:1]};
    if (c[7]) begin
      c = c ^ POLY;
    end
    return c;
  endfunction

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pos         = 3'(byte_count);

  // The checksum never includes the newest stored byte, so it lags by one byte.
  assign store_accum = (byte_count != '0) ? fold(check_accum, held_byte) : check_accum;

  always_comb begin
    logic do_store;
    logic do_drop;
    logic bad_hdr;
    do_store           = 1'b0;
    do_drop            = 1'b0;
    byte_count_next    = byte_count;
    frame_length_next  = frame_length;
    stuff_pending_next = stuff_pending;
    check_accum_next   = check_accum;
    held_byte_next     = held_byte;
    res_status         = ST_RESTARTED;
    res_byte           = '0;
    res_index          = '0;
    bad_hdr = (pos == POS_HDR0 && in_ch.rx_byte != HDR0) ||
              (pos == POS_HDR1 && in_ch.rx_byte != HDR1) ||
              (pos == POS_HDR2 && in_ch.rx_byte != HDR2);

    if (in_ch.mode) begin
      res_status = ST_RESTARTED;
      do_drop    = 1'b1;
    end else if (byte_count < CNT_W'(HDR_LEN)) begin
      if (bad_hdr) begin
        res_status = ST_HDR_REJECT;
        do_drop    = 1'b1;
      end else if (pos == POS_ADDR && in_ch.rx_byte != {4'h0, device_address}) begin
        res_status = ST_ADDR_REJECT;
        do_drop    = 1'b1;
      end else begin
        do_store = 1'b1;
        if (pos == POS_HDR0) begin
          stuff_pending_next = 1'b0;
        end
        if (pos == POS_LEN) begin
          frame_length_next = in_ch.rx_byte;
        end
        res_status = ST_HDR_OK;
        res_byte   = in_ch.rx_byte;
        res_index  = 8'(byte_count);
      end
    end else if (in_ch.rx_byte == STUFF && stuff_pending) begin
      stuff_pending_next = 1'b0;
      res_status         = ST_STUFF_DROP;
    end else if (byte_count >= CNT_W'(BUF_DEPTH)) begin
      res_status = ST_OVERFLOW;
      do_drop    = 1'b1;
    end else begin
      stuff_pending_next = (in_ch.rx_byte == HDR1);
      do_store           = 1'b1;
      res_byte           = in_ch.rx_byte;
      res_index          = 8'(byte_count);
      if (CMP_W'(byte_count) + CMP_W'(1) >= CMP_W'(frame_length) + CMP_W'(HDR_LEN)) begin
        res_status = (store_accum == in_ch.rx_byte) ? ST_FRAME_GOOD : ST_CHECK_BAD;
        do_drop    = 1'b1;
      end else begin
        res_status = ST_STORED;
      end
    end

    if (do_store) begin
      check_accum_next = store_accum;
      held_byte_next   = in_ch.rx_byte;
      byte_count_next  = byte_count + CNT_W'(1);
    end
    if (do_drop) begin
      byte_count_next    = '0;
      stuff_pending_next = 1'b0;
      check_accum_next   = '0;
      held_byte_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_DEF;
    end else if (cfg_write) begin
      device_address <= (cfg_data == 4'h0) ? ADDR_DEF : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      frame_length  <= '0;
      stuff_pending <= 1'b0;
      check_accum   <= '0;
      held_byte     <= '0;
    end else if (in_fire) begin
      byte_count    <= byte_count_next;
      frame_length  <= frame_length_next;
      stuff_pending <= stuff_pending_next;
      check_accum   <= check_accum_next;
      held_byte     <= held_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (in_fire) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ch.status       <= res_status;
      out_ch.stored_byte  <= res_byte;
      out_ch.byte_index   <= res_index;
      out_ch.length_field <= frame_length_next;
      out_ch.frame_end    <= (res_status >= ST_FRAME_GOOD);
    end
  end

  // A restart always empties the frame and reports itself in the next cycle.
  `ASSERT_NEXT(a_restart_drops, clk, rst, in_fire && in_ch.mode, out_ch.valid && out_ch.status == ST_RESTARTED && byte_count == '0)
  // The fill count never runs past the buffer.
  `ASSERT_SAME(a_count_bound, clk, rst, 1'b1, byte_count <= CNT_W'(BUF_DEPTH))
  // Stuffing can only be pending once a data byte has followed the header.
  `ASSERT_SAME(a_stuff_in_data, clk, rst, stuff_pending, byte_count > CNT_W'(HDR_LEN))
  // Data bytes are only ever stored after the six header positions.
  `ASSERT_SAME(a_data_index, clk, rst, out_ch.valid && out_ch.status == ST_STORED, out_ch.byte_index >= 8'(HDR_LEN))

endmodule

// File: bench/tb.sv
// Self-checking testbench for the RS-485 frame receiver: frame stimulus, prediction and checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfr_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    status_t    status;
    logic [7:0] stored_byte;
    logic [7:0] byte_index;
    logic [7:0] length_field;
    logic       frame_end;
  } frame_result_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } rx_item_t;

  class frame_scoreboard;
    logic [3:0]    node_addr;
    int unsigned   stored_cnt;
    logic [7:0]    length_reg;
    logic [7:0]    accum;
    logic [7:0]    held;
    bit            stuff_seen;
    frame_result_t pending_q[$];
    int            errors;
    int            results_seen;
    int            status_hits [9];

    function new();
      node_addr = ADDR_DEF;
      length_reg = 8'h00;
      errors = 0;
      results_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      drop();
    endfunction

    function logic [7:0] fold(logic [7:0] acc, logic [7:0] b);
      logic [7:0] c;
      c = acc ^ b;
      c = {c[0], c[7:1]};
      if (c[7]) c = c ^ POLY;
      return c;
    endfunction

    function void drop();
      stored_cnt = 0;
      stuff_seen = 1'b0;
      accum = 8'h00;
      held = 8'h00;
    endfunction

    // The checksum trails by one byte, so that the newest byte can be compared with it.
    function void keep_byte(logic [7:0] b);
      if (stored_cnt > 0) accum = fold(accum, held);
      held = b;
      stored_cnt++;
    endfunction

    function void set_address(logic [3:0] a);
      node_addr = (a == 4'h0) ? ADDR_DEF : a;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void note_input(logic mode, logic [7:0] b);
      frame_result_t r;
      int unsigned   pos;
      r = '0;
      pos = stored_cnt;
      if (mode) begin
        r.status = ST_RESTARTED;
        drop();
      end else if (pos < HDR_LEN) begin
        if ((pos == POS_HDR0 && b != HDR0) || (pos == POS_HDR1 && b != HDR1) ||
            (pos == POS_HDR2 && b != HDR2)) begin
          r.status = ST_HDR_REJECT;
          drop();
        end else if (pos == POS_ADDR && b != {4'h0, node_addr}) begin
          r.status = ST_ADDR_REJECT;
          drop();
        end else begin
          if (pos == POS_HDR0) stuff_seen = 1'b0;
          keep_byte(b);
          if (pos == POS_LEN) length_reg = b;
          r.status = ST_HDR_OK;
          r.stored_byte = b;
          r.byte_index = pos[7:0];
        end
      end else if (b == STUFF && stuff_seen) begin
        stuff_seen = 1'b0;
        r.status = ST_STUFF_DROP;
      end else if (pos >= BUF_DEPTH) begin
        r.status = ST_OVERFLOW;
        drop();
      end else begin
        stuff_seen = (b == HDR1);
        keep_byte(b);
        r.stored_byte = b;
        r.byte_index = pos[7:0];
        if (stored_cnt >= length_reg + HDR_LEN) begin
          r.status = (accum == b) ? ST_FRAME_GOOD : ST_CHECK_BAD;
          drop();
        end else begin
          r.status = ST_STORED;
        end
      end
      r.length_field = length_reg;
      r.frame_end = (r.status >= ST_FRAME_GOOD);
      status_hits[int'(r.status)]++;
      pending_q.push_back(r);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected result: status %0d byte %02h index %0d length %0d end %0b",
                   $time, got.status, got.stored_byte, got.byte_index, got.length_field,
                   got.frame_end);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 30) begin
          $write("%0t: expected status %0d byte %02h index %0d length %0d end %0b, ", $time,
                 want.status, want.stored_byte, want.byte_index, want.length_field,
                 want.frame_end);
          $display("got status %0d byte %02h index %0d length %0d end %0b",
                   got.status, got.stored_byte, got.byte_index, got.length_field,
                   got.frame_end);
        end
      end
    endfunction
  endclass

  bit         clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write;
  logic [3:0] cfg_data;

  rfr_in_if  in_ch ();
  rfr_out_if out_ch ();

  rs485_frame_receiver dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  frame_scoreboard sb;
  rx_item_t        stim_q[$];
  bit              src_idle = 1'b1;
  bit              sink_idle = 1'b1;
  bit              hold_req = 1'b0;
  int              items_sent = 0;
  int              stall_cycles = 0;
  logic [3:0]      mid_addr;

  always #6 clk = ~clk;

  // Monitor both channels and watch for a stuck handshake.
  always @(posedge clk) begin
    frame_result_t got;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.stored_byte = out_ch.stored_byte;
        got.byte_index = out_ch.byte_index;
        got.length_field = out_ch.length_field;
        got.frame_end = out_ch.frame_end;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.mode, in_ch.rx_byte);
    end
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a transaction.", STALL_LIMIT);
      $display("rs485_frame_receiver: mismatch");
      $finish;
    end
  end

  // Result receiver: random back-pressure, or one long hold-off when asked.
  initial begin
    out_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= !sink_idle || ($urandom_range(0, 99) >= 33);
        @(posedge clk);
      end
    end
  end

  function automatic void push_rx(logic mode, logic [7:0] b);
    rx_item_t it;
    it.mode = mode;
    it.rx_byte = b;
    stim_q.push_back(it);
  endfunction

  // Queues the six header bytes and returns the checksum over them.
  function automatic logic [7:0] push_header(logic [7:0] addr_byte, logic [7:0] len);
    logic [7:0] hb [6];
    logic [7:0] acc;
    logic [7:0] cmd;
    cmd = 8'($urandom_range(0, 255));
    hb = '{HDR0, HDR1, HDR2, addr_byte, cmd, len};
    acc = 8'h00;
    foreach (hb[i]) begin
      push_rx(1'b0, hb[i]);
      acc = sb.fold(acc, hb[i]);
    end
    return acc;
  endfunction

  function automatic void push_frame(int len, bit bad_addr, bit bad_sum, bit skip_stuff);
    logic [7:0] acc;
    logic [7:0] a;
    logic [7:0] d;
    int         rest;
    int         r;
    a = {4'h0, sb.node_addr};
    if (bad_addr) begin
      a = 8'($urandom_range(0, 255));
      if (a == {4'h0, sb.node_addr}) a = a ^ 8'h01;
    end
    acc = push_header(a, len[7:0]);
    // A frame always carries at least its checksum byte after the header.
    rest = (len < 1) ? 1 : len;
    for (int i = 1; i < rest; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) d = HDR1;
      else if (r < 25) d = STUFF;
      else d = 8'($urandom_range(0, 255));
      push_rx(1'b0, d);
      acc = sb.fold(acc, d);
      if (d == HDR1 && !skip_stuff) push_rx(1'b0, STUFF);
    end
    if (bad_sum) acc = acc ^ (8'h01 << $urandom_range(0, 7));
    push_rx(1'b0, acc);
  endfunction

  // Fills the buffer to its last entry with a D7, lets a stuffing byte through, then overflows.
  function automatic void push_overflow_frame();
    logic [7:0] d;
    void'(push_header({4'h0, sb.node_addr}, 8'hFF));
    for (int i = HDR_LEN; i < BUF_DEPTH - 1; i++) begin
      d = 8'($urandom_range(0, 255));
      if (d == HDR1) d = 8'h5A;
      push_rx(1'b0, d);
    end
    push_rx(1'b0, HDR1);
    push_rx(1'b0, STUFF);
    push_rx(1'b0, 8'($urandom_range(0, 255)));
  endfunction

  task automatic send_item(rx_item_t it);
    if (src_idle)
      while ($urandom_range(0, 99) < 33) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    in_ch.valid <= 1'b1;
    in_ch.mode <= it.mode;
    in_ch.rx_byte <= it.rx_byte;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic play_queue();
    @(posedge clk);
    foreach (stim_q[i]) send_item(stim_q[i]);
    in_ch.valid <= 1'b0;
    items_sent += stim_q.size();
    stim_q.delete();
  endtask

  task automatic write_address(logic [3:0] a);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= a;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_address(a);
  endtask

  task automatic run_random(int target);
    int r;
    int len;
    while (stim_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        push_frame(len, $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 12,
                   $urandom_range(0, 99) < 8);
        // Now and then the frame is cut short by a restart.
        if ($urandom_range(0, 99) < 8) begin
          repeat ($urandom_range(1, 4)) void'(stim_q.pop_back());
          push_rx(1'b1, 8'($urandom_range(0, 255)));
        end
      end else if (r < 88) begin
        repeat ($urandom_range(1, 4)) push_rx(1'b0, 8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        push_rx(1'b1, 8'($urandom_range(0, 255)));
      end else begin
        push_rx(1'b0, HDR0);
        push_rx(1'b0, ($urandom_range(0, 99) < 50) ? HDR1 : 8'($urandom_range(0, 255)));
      end
    end
    play_queue();
  endtask

  initial begin
    logic [7:0] acc;
    cfg_write = 1'b0;
    cfg_data = 4'h0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.rx_byte = 8'h00;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset address: header rejects, restart, address reject,
    // a good frame with a stuffing byte and a frame with a bad checksum.
    push_rx(1'b0, 8'hFF);
    push_rx(1'b0, HDR0);
    push_rx(1'b0, HDR1);
    push_rx(1'b0, 8'hFF);
    push_rx(1'b0, HDR0);
    push_rx(1'b0, HDR1);
    push_rx(1'b1, 8'hA5);
    push_rx(1'b0, HDR0);
    push_rx(1'b0, HDR1);
    push_rx(1'b0, HDR2);
    push_rx(1'b0, 8'h02);
    acc = push_header({4'h0, ADDR_DEF}, 8'h02);
    push_rx(1'b0, HDR1);
    acc = sb.fold(acc, HDR1);
    push_rx(1'b0, STUFF);
    push_rx(1'b0, acc);
    push_frame(0, 1'b0, 1'b1, 1'b0);
    play_queue();

    // Highest address, with one long hold-off on the result side.
    write_address(4'hF);
    hold_req = 1'b1;
    run_random(85);

    // Zero is taken as address one; this stretch runs without any idling.
    write_address(4'h0);
    src_idle = 1'b0;
    sink_idle = 1'b0;
    run_random(85);
    src_idle = 1'b1;
    sink_idle = 1'b1;

    mid_addr = 4'($urandom_range(2, 14));
    write_address(mid_addr);
    run_random(85);

    // A frame that runs the buffer to its last entry and then overflows it, then normal traffic.
    write_address(4'h1);
    push_overflow_frame();
    push_frame(3, 1'b0, 1'b0, 1'b0);
    play_queue();
    run_random(80);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes and restarts, checked %0d results: %0d good frames, %0d bad %s",
             items_sent, sb.results_seen, sb.status_hits[int'(ST_FRAME_GOOD)],
             sb.status_hits[int'(ST_CHECK_BAD)], "checksums");
    $display("Overflows %0d, stuffing removed %0d, rejects %0d, restarts %0d; addresses 15, 1, %0d.",
             sb.status_hits[int'(ST_OVERFLOW)], sb.status_hits[int'(ST_STUFF_DROP)],
             sb.status_hits[int'(ST_HDR_REJECT)] + sb.status_hits[int'(ST_ADDR_REJECT)],
             sb.status_hits[int'(ST_RESTARTED)], mid_addr);
    if (sb.errors == 0)
      $display("rs485_frame_receiver: match");
    else
      $display("rs485_frame_receiver: mismatch");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/rfr_pkg.sv
rtl/rfr_in_if.sv
rtl/rfr_out_if.sv
rtl/rs485_frame_receiver.sv
bench/tb.sv
